// ===== hdl/hle_pkg.sv =====
// Shared types, constants and helpers for the hardening law evaluator.
// Used by hle_log2_cell, hle_series_cell, hle_pow_lane and hardening_law_eval.
package hle_pkg;

  typedef enum logic [1:0] {
    MODE_LINEAR  = 2'd0,
    MODE_POW_LIN = 2'd1,
    MODE_EXP     = 2'd2,
    MODE_POW     = 2'd3
  } mode_e;

  localparam logic [2:0] CFG_MODE  = 3'd0;
  localparam logic [2:0] CFG_GAIN  = 3'd1;
  localparam logic [2:0] CFG_EXPO  = 3'd2;
  localparam logic [2:0] CFG_RATE  = 3'd3;
  localparam logic [2:0] CFG_CAP   = 3'd4;
  localparam logic [2:0] CFG_AMP   = 3'd5;
  localparam logic [2:0] CFG_SLOPE = 3'd6;
  localparam logic [2:0] CFG_TOFF  = 3'd7;

  localparam int EXPO_FRAC    = 16;
  localparam int LOG2_STEPS   = 30;
  localparam int SERIES_TERMS = 12;
  // normalize + log2 steps + exponent multiply + fraction split + 3 per term + shift
  localparam int LANE_LAT     = 1 + LOG2_STEPS + 1 + 1 + 3 * SERIES_TERMS + 1;

  localparam logic signed [24:0] EXPO_ONE  = 25'sd65536;
  localparam logic [30:0]        ONE30     = 31'd1073741824;
  localparam logic [29:0]        LN2_Q30   = 30'd744261118;
  localparam logic [30:0]        LOG2E_Q30 = 31'd1549082005;
  localparam logic [30:0]        POW_MAX   = 31'h7fffffff;
  localparam logic signed [31:0] I32MAX    = 32'sh7fffffff;
  localparam logic signed [31:0] I32MIN    = 32'sh80000000;

  typedef struct packed {
    logic [30:0]        b;
    logic signed [24:0] e;
    logic               use_y;
    logic               y_zero;
    logic signed [47:0] y;
  } lane_in_t;

  typedef struct packed {
    logic [4:0]         p;
    logic signed [24:0] e;
    logic               use_y;
    logic signed [47:0] y;
    logic               spec;
    logic [30:0]        spec_val;
    logic               spec_flag;
  } l2_ctl_t;

  typedef struct packed {
    logic signed [17:0] k;
    logic               spec;
    logic [30:0]        spec_val;
    logic               spec_flag;
  } ser_ctl_t;

  typedef struct packed {
    mode_e              mode;
    logic               direct;
    logic               fpre;
    logic signed [31:0] g_pre;
    logic signed [31:0] d_pre;
    logic signed [31:0] kn;
  } side_t;

  function automatic logic [4:0] lead_one(input logic [30:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 31; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return I32MAX;
    else if (v < -64'sd2147483648) return I32MIN;
    else return $signed(v[31:0]);
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

endpackage

// ===== hdl/hardening_law_eval.sv =====
// Hardening law evaluator top level: config registers, operand setup,
// two power lanes (hle_pow_lane) and result assembly. Depends on hle_pkg.
//
//   channel   signals                                 direction
//   input     in_valid_i / in_ready_o, plastic_strain_i        in
//   output    out_valid_o / out_ready_i, relative_yield_o,
//             yield_slope_o, saturated_o                        out
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i                  in
//
// One beat per cycle unless stalled; depth is set by the two power lanes
// (30 log2 cells, 12 three-stage series cells) plus setup and assembly stages.
// The whole pipeline advances when the output register is empty or taken,
// so a stalled output holds every stage. Reset clears the valid bits and
// loads the register reset values.
module hardening_law_eval #(
  parameter int FRAC_BITS    = 16,
  parameter int STRAIN_FLOOR = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [30:0]         plastic_strain_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  relative_yield_o,
  output logic signed [31:0]  yield_slope_o,
  output logic                saturated_o
);
  import hle_pkg::*;

  localparam logic signed [31:0] ONE     = 32'sh1 << FRAC_BITS;
  localparam int                 ZW      = FRAC_BITS + 6;
  localparam logic [61:0]        EXP_LIM = 62'd64 << FRAC_BITS;
  localparam logic [30:0]        FLOOR   = 31'(STRAIN_FLOOR);

  // configuration
  mode_e              mode_q;
  logic signed [31:0] gain_q, cap_q, amp_q, slope_q, toff_q;
  logic [23:0]        expo_q;
  logic [30:0]        rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_LINEAR;
      gain_q  <= '0;
      expo_q  <= 24'(EXPO_ONE);
      rate_q  <= '0;
      cap_q   <= -ONE;
      amp_q   <= '0;
      slope_q <= '0;
      toff_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:  mode_q  <= mode_e'(cfg_wdata_i[1:0]);
        CFG_GAIN:  gain_q  <= $signed(cfg_wdata_i);
        CFG_EXPO:  expo_q  <= cfg_wdata_i[23:0];
        CFG_RATE:  rate_q  <= cfg_wdata_i[30:0];
        CFG_CAP:   cap_q   <= $signed(cfg_wdata_i);
        CFG_AMP:   amp_q   <= $signed(cfg_wdata_i);
        CFG_SLOPE: slope_q <= $signed(cfg_wdata_i);
        CFG_TOFF:  toff_q  <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  logic adv;
  logic v1_q, v2_q;
  logic vp_q [LANE_LAT + 1];

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // stage 1: products
  logic [30:0]        a1_q;
  logic               capsel1_q;
  logic signed [63:0] pka_q, pkn_q, pt_q;
  logic [61:0]        pz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_q      <= plastic_strain_i;
      capsel1_q <= cap_q[31] || ($signed({1'b0, plastic_strain_i}) < cap_q);
      pka_q     <= 64'(gain_q) * 64'($signed({1'b0, plastic_strain_i}));
      pkn_q     <= 64'(gain_q) * 64'($signed({1'b0, expo_q}));
      pz_q      <= 62'(rate_q) * 62'(plastic_strain_i);
      pt_q      <= 64'(slope_q) * 64'($signed({1'b0, plastic_strain_i}));
    end
  end

  // stage 2: operand setup
  logic signed [31:0] mka, base, kn, mt, gt;
  logic               fl1, fl2, flk, flt1, flt2;
  logic [61:0]        z;
  logic [ZW+30:0]     zprod;
  logic [36:0]        yz;
  logic signed [24:0] nm1;
  lane_in_t           la_d, lb_d, la_q, lb_q;
  side_t              side_d;
  side_t              side_p [LANE_LAT + 1];

  always_comb begin
    mka   = sat32(pka_q >>> FRAC_BITS);
    fl1   = ovf32(pka_q >>> FRAC_BITS);
    base  = sat32(64'(ONE) + 64'(mka));
    fl2   = ovf32(64'(ONE) + 64'(mka));
    kn    = sat32(pkn_q >>> EXPO_FRAC);
    flk   = ovf32(pkn_q >>> EXPO_FRAC);
    mt    = sat32(pt_q >>> FRAC_BITS);
    flt1  = ovf32(pt_q >>> FRAC_BITS);
    gt    = sat32(64'(toff_q) + 64'(mt));
    flt2  = ovf32(64'(toff_q) + 64'(mt));
    z     = pz_q >> FRAC_BITS;
    zprod = (ZW + 31)'(z[ZW-1:0]) * (ZW + 31)'(LOG2E_Q30);
    yz    = 37'(zprod >> FRAC_BITS);
    nm1   = $signed({1'b0, expo_q}) - EXPO_ONE;

    la_d.b      = a1_q;
    la_d.e      = $signed({1'b0, expo_q});
    la_d.use_y  = 1'b0;
    la_d.y_zero = (z >= EXP_LIM);
    la_d.y      = -$signed({11'b0, yz});
    lb_d        = la_d;
    lb_d.e      = nm1;
    lb_d.b      = ((la_d.e < EXPO_ONE) && (a1_q < FLOOR)) ? FLOOR : a1_q;

    side_d.mode   = mode_q;
    side_d.kn     = kn;
    side_d.direct = 1'b0;
    side_d.fpre   = flk;
    side_d.g_pre  = base;
    side_d.d_pre  = gain_q;

    case (mode_q)
      MODE_LINEAR: begin
        side_d.direct = 1'b1;
        side_d.fpre   = flk | fl1 | fl2;
      end
      MODE_POW_LIN: begin
        la_d.b      = base[30:0];
        lb_d.b      = base[30:0];
        side_d.fpre = flk | fl1 | fl2;
        if (base[31]) begin
          side_d.direct = 1'b1;
          side_d.fpre   = 1'b1;
          side_d.g_pre  = '0;
          side_d.d_pre  = '0;
        end
      end
      MODE_EXP: begin
        la_d.use_y = 1'b1;
        if (!capsel1_q) begin
          side_d.direct = 1'b1;
          side_d.fpre   = flk | flt1 | flt2;
          side_d.g_pre  = gt;
          side_d.d_pre  = slope_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      la_q      <= la_d;
      lb_q      <= lb_d;
      side_p[0] <= side_d;
      for (int i = 1; i <= LANE_LAT; i++) side_p[i] <= side_p[i-1];
    end
  end

  logic [30:0] pa, pb;
  logic        fa, fb;

  hle_pow_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_a (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .in_i   (la_q),
    .pow_o  (pa),
    .flag_o (fa)
  );

  hle_pow_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_b (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .in_i   (lb_q),
    .pow_o  (pb),
    .flag_o (fb)
  );

  // assembly stage 1: scale products
  side_t              sl;
  logic signed [31:0] pwa, pwb, m1a, m1b, m2a, m2b;
  logic signed [63:0] m1_q, m2_q;
  logic signed [31:0] pwa_q;
  logic               fl_q;
  side_t              side_q;

  always_comb begin
    sl  = side_p[LANE_LAT];
    pwa = $signed({1'b0, pa});
    pwb = $signed({1'b0, pb});
    if (sl.mode == MODE_EXP) begin
      m1a = amp_q;
      m1b = ONE - pwa;
      m2a = gain_q;
      m2b = pwa;
    end else begin
      m1a = gain_q;
      m1b = pwa;
      m2a = sl.kn;
      m2b = pwb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q   <= 64'(m1a) * 64'(m1b);
      m2_q   <= 64'(m2a) * 64'(m2b);
      pwa_q  <= pwa;
      fl_q   <= (sl.mode == MODE_EXP) ? fa : (fa | fb);
      side_q <= sl;
    end
  end

  // assembly stage 2: result register
  logic signed [31:0] q1, g1, q2, g_d, d_d;
  logic               f_d;

  always_comb begin
    q1  = sat32(m1_q >>> FRAC_BITS);
    g1  = sat32(64'(ONE) + 64'(q1));
    q2  = sat32(m2_q >>> FRAC_BITS);
    g_d = g1;
    d_d = q2;
    f_d = side_q.fpre | fl_q | ovf32(m1_q >>> FRAC_BITS)
        | ovf32(64'(ONE) + 64'(q1)) | ovf32(m2_q >>> FRAC_BITS);
    if (side_q.direct) begin
      g_d = side_q.g_pre;
      d_d = side_q.d_pre;
      f_d = side_q.fpre;
    end else if (side_q.mode == MODE_POW_LIN) begin
      g_d = pwa_q;
      f_d = side_q.fpre | fl_q | ovf32(m2_q >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      relative_yield_o <= g_d;
      yield_slope_o    <= d_d;
      saturated_o      <= f_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_o <= 1'b0;
      for (int i = 0; i <= LANE_LAT; i++) vp_q[i] <= 1'b0;
    end else if (adv) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      vp_q[0] <= v2_q;
      for (int i = 1; i <= LANE_LAT; i++) vp_q[i] <= vp_q[i-1];
      out_valid_o <= vp_q[LANE_LAT];
    end
  end

endmodule

// ===== hdl/hle_log2_cell.sv =====
// One square-and-compare step of the log2 fraction.
// Depends on hle_pkg.
module hle_log2_cell #(
  parameter int IDX = 1
) (
  input  logic                clk_i,
  input  logic                adv_i,
  input  logic [30:0]         m_i,
  input  logic [29:0]         frac_i,
  input  hle_pkg::l2_ctl_t    ctl_i,
  output logic [30:0]         m_o,
  output logic [29:0]         frac_o,
  output hle_pkg::l2_ctl_t    ctl_o
);
  import hle_pkg::*;

  logic [61:0] sq;
  logic [31:0] m2;
  logic [30:0] m_d;
  logic [29:0] frac_d;

  always_comb begin
    sq     = 62'(m_i) * 62'(m_i);
    m2     = sq[61:30];
    frac_d = frac_i;
    if (m2[31]) begin
      m_d                 = m2[31:1];
      frac_d[LOG2_STEPS - IDX] = 1'b1;
    end else begin
      m_d = m2[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      m_o    <= m_d;
      frac_o <= frac_d;
      ctl_o  <= ctl_i;
    end
  end

endmodule

// ===== hdl/hle_series_cell.sv =====
// One term of the 2^f series: term = (term * t >> 30) / IDX, three stages.
// Depends on hle_pkg.
module hle_series_cell #(
  parameter int IDX = 1
) (
  input  logic                clk_i,
  input  logic                adv_i,
  input  logic [30:0]         term_i,
  input  logic [31:0]         sum_i,
  input  logic [29:0]         t_i,
  input  hle_pkg::ser_ctl_t   ctl_i,
  output logic [30:0]         term_o,
  output logic [31:0]         sum_o,
  output logic [29:0]         t_o,
  output hle_pkg::ser_ctl_t   ctl_o
);
  import hle_pkg::*;

  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(IDX));
  localparam logic [30:0] DIV   = 31'(IDX);

  logic [60:0] prod_q;
  logic [31:0] sum_a_q, sum_b_q;
  logic [29:0] t_a_q, t_b_q;
  ser_ctl_t    ctl_a_q, ctl_b_q;
  logic [30:0] x_q;
  logic [63:0] qm_q;

  logic [30:0] x_d;
  logic [30:0] q0, rem, q;

  always_comb begin
    x_d = prod_q[60:30];
    q0  = qm_q[62:32];
    rem = x_q - 31'(q0 * DIV);
    q   = (rem >= DIV) ? q0 + 31'd1 : q0;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q  <= 61'(term_i) * 61'(t_i);
      sum_a_q <= sum_i;
      t_a_q   <= t_i;
      ctl_a_q <= ctl_i;
      x_q     <= x_d;
      qm_q    <= 64'(x_d) * 64'(RECIP);
      sum_b_q <= sum_a_q;
      t_b_q   <= t_a_q;
      ctl_b_q <= ctl_a_q;
      term_o  <= q;
      sum_o   <= sum_b_q + 32'(q);
      t_o     <= t_b_q;
      ctl_o   <= ctl_b_q;
    end
  end

endmodule

// ===== hdl/hle_pow_lane.sv =====
// Power lane: b^e = 2^(log2(b)*e), or 2^y for a given y, as a chain of cells.
// Depends on hle_pkg, hle_log2_cell and hle_series_cell.
module hle_pow_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                adv_i,
  input  hle_pkg::lane_in_t   in_i,
  output logic [30:0]         pow_o,
  output logic                flag_o
);
  import hle_pkg::*;

  localparam logic [30:0]        ONE_F = 31'd1 << FRAC_BITS;
  localparam logic signed [7:0]  FB    = 8'(FRAC_BITS);
  localparam logic signed [19:0] SOFF  = 20'(FRAC_BITS - 30);

  logic [30:0] m_c    [LOG2_STEPS + 1];
  logic [29:0] frac_c [LOG2_STEPS + 1];
  l2_ctl_t     ctl_c  [LOG2_STEPS + 1];

  l2_ctl_t     n_ctl;
  logic [4:0]  n_p;

  always_comb begin
    n_p           = lead_one(in_i.b);
    n_ctl.p       = n_p;
    n_ctl.e       = in_i.e;
    n_ctl.use_y   = in_i.use_y;
    n_ctl.y       = in_i.y;
    n_ctl.spec    = 1'b0;
    n_ctl.spec_val  = '0;
    n_ctl.spec_flag = 1'b0;
    if (in_i.use_y) begin
      n_ctl.spec = in_i.y_zero;
    end else if (in_i.e == '0) begin
      n_ctl.spec     = 1'b1;
      n_ctl.spec_val = ONE_F;
    end else if (in_i.e == EXPO_ONE) begin
      n_ctl.spec     = 1'b1;
      n_ctl.spec_val = in_i.b;
    end else if (in_i.b == '0) begin
      n_ctl.spec = 1'b1;
      if (in_i.e < 0) begin
        n_ctl.spec_val  = POW_MAX;
        n_ctl.spec_flag = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      m_c[0]    <= 31'(in_i.b << (5'd30 - n_p));
      frac_c[0] <= '0;
      ctl_c[0]  <= n_ctl;
    end
  end

  for (genvar i = 1; i <= LOG2_STEPS; i++) begin : g_log2
    hle_log2_cell #(.IDX(i)) u_cell (
      .clk_i  (clk_i),
      .adv_i  (adv_i),
      .m_i    (m_c[i-1]),
      .frac_i (frac_c[i-1]),
      .ctl_i  (ctl_c[i-1]),
      .m_o    (m_c[i]),
      .frac_o (frac_c[i]),
      .ctl_o  (ctl_c[i])
    );
  end

  // log2 times exponent
  logic signed [7:0]  lsh;
  logic signed [37:0] l_val;
  logic signed [62:0] lprod_q;
  l2_ctl_t            mctl_q;

  always_comb begin
    lsh   = $signed({3'b0, ctl_c[LOG2_STEPS].p}) - FB;
    l_val = $signed({lsh, frac_c[LOG2_STEPS]});
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lprod_q <= 63'(l_val) * 63'(ctl_c[LOG2_STEPS].e);
      mctl_q  <= ctl_c[LOG2_STEPS];
    end
  end

  // split y into integer and fraction, scale the fraction by ln2
  logic signed [47:0] y_v;
  logic [59:0]        tprod;
  ser_ctl_t           tctl;

  logic [30:0] term_c [SERIES_TERMS + 1];
  logic [31:0] sum_c  [SERIES_TERMS + 1];
  logic [29:0] t_c    [SERIES_TERMS + 1];
  ser_ctl_t    sctl_c [SERIES_TERMS + 1];

  always_comb begin
    y_v            = mctl_q.use_y ? mctl_q.y : 48'(lprod_q >>> EXPO_FRAC);
    tprod          = 60'(y_v[29:0]) * 60'(LN2_Q30);
    tctl.k         = 18'(y_v >>> 30);
    tctl.spec      = mctl_q.spec;
    tctl.spec_val  = mctl_q.spec_val;
    tctl.spec_flag = mctl_q.spec_flag;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      term_c[0] <= ONE30;
      sum_c[0]  <= 32'(ONE30);
      t_c[0]    <= tprod[59:30];
      sctl_c[0] <= tctl;
    end
  end

  for (genvar i = 1; i <= SERIES_TERMS; i++) begin : g_series
    hle_series_cell #(.IDX(i)) u_cell (
      .clk_i  (clk_i),
      .adv_i  (adv_i),
      .term_i (term_c[i-1]),
      .sum_i  (sum_c[i-1]),
      .t_i    (t_c[i-1]),
      .ctl_i  (sctl_c[i-1]),
      .term_o (term_c[i]),
      .sum_o  (sum_c[i]),
      .t_o    (t_c[i]),
      .ctl_o  (sctl_c[i])
    );
  end

  // scale by 2^(k + F - 30)
  ser_ctl_t           fctl;
  logic [31:0]        fsum;
  logic signed [19:0] s, ns;
  logic [63:0]        v;
  logic [30:0]        pow_d;
  logic               flag_d;

  always_comb begin
    fctl   = sctl_c[SERIES_TERMS];
    fsum   = sum_c[SERIES_TERMS];
    s      = 20'(fctl.k) + SOFF;
    ns     = -s;
    v      = 64'(fsum) << s[4:0];
    pow_d  = '0;
    flag_d = 1'b0;
    if (fctl.spec) begin
      pow_d  = fctl.spec_val;
      flag_d = fctl.spec_flag;
    end else if (s >= 20'sd31) begin
      pow_d  = POW_MAX;
      flag_d = 1'b1;
    end else if (s >= 0) begin
      if (v > 64'(POW_MAX)) begin
        pow_d  = POW_MAX;
        flag_d = 1'b1;
      end else begin
        pow_d = v[30:0];
      end
    end else if (ns < 20'sd32) begin
      pow_d = 31'(fsum >> ns[4:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pow_o  <= pow_d;
      flag_o <= flag_d;
    end
  end

endmodule
